// ===== rtl/lkv_pkg.sv =====
// Package for the LRU key/value cache: sizes, command codes and payload structs.
// Used by lru_key_value_cache_top and lkv_checker; depends on nothing.
`default_nettype none

package lkv_pkg;

  localparam int ENTRIES    = 8;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CAP_BITS   = 4;
  localparam int CAP_RESET  = 8;
  localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);
  localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  typedef enum logic {
    CMD_PUT = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lkv_in_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } lkv_out_t;

endpackage

`default_nettype wire

// ===== rtl/lru_key_value_cache_top.sv =====
// Each access is captured in the input register, and its result in the result register.
// Throughput: one transfer per cycle unless stalled; lookup and rank update are combinational.
// Reset (rst_n, synchronous, active low) clears all valid bits, recency ranks, the fill count
// and the result valid flag, and sets capacity to 8; keys and values are not cleared and no
// clearing pass is needed.
// Top level of the LRU key/value cache; depends on lkv_pkg.
`default_nettype none

module lru_key_value_cache_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire lkv_pkg::lkv_in_t        in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output lkv_pkg::lkv_out_t            out_data,
  input  wire                          cfg_wr_en,
  input  wire [lkv_pkg::CAP_BITS-1:0]  cfg_wr_data
);

  localparam int N  = lkv_pkg::ENTRIES;
  localparam int RB = lkv_pkg::RANK_BITS;
  localparam int CB = lkv_pkg::CNT_BITS;
  localparam int MB = lkv_pkg::CMP_BITS;

  logic                            s1_valid_r;
  lkv_pkg::lkv_in_t                s1_data_r;
  logic                            out_valid_r;
  lkv_pkg::lkv_out_t               out_data_r;
  logic [lkv_pkg::CAP_BITS-1:0]    cap_r;
  logic [lkv_pkg::KEY_BITS-1:0]    key_r [N];
  logic [lkv_pkg::VALUE_BITS-1:0]  val_r [N];
  logic [N-1:0]                    valid_r;
  logic [RB-1:0]                   rank_r [N];
  logic [CB-1:0]                   used_r;

  logic [N-1:0]                    valid_nxt;
  logic [RB-1:0]                   rank_nxt [N];
  logic [CB-1:0]                   used_nxt;
  lkv_pkg::lkv_out_t               out_data_nxt;

  logic                            go;
  logic                            is_put;
  logic                            hit;
  logic                            room;
  logic                            put_new;
  logic                            upd;
  logic [MB-1:0]                   cap_eff;
  logic [N-1:0]                    match;
  logic [N-1:0]                    inv;
  logic [N-1:0]                    free_oh;
  logic [N-1:0]                    oldest_oh;
  logic [N-1:0]                    sel;
  logic [RB-1:0]                   sel_rank;
  logic [CB-1:0]                   thr;
  logic [lkv_pkg::KEY_BITS-1:0]    sel_key;
  logic [lkv_pkg::VALUE_BITS-1:0]  sel_val;

  assign go        = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = MB'(1);
    end else if (MB'(cap_r) > MB'(N)) begin
      cap_eff = MB'(N);
    end else begin
      cap_eff = MB'(cap_r);
    end

    is_put = (s1_data_r.command == lkv_pkg::CMD_PUT);
    for (int i = 0; i < N; i++) begin
      match[i]     = valid_r[i] && (key_r[i] == s1_data_r.key);
      oldest_oh[i] = valid_r[i] && (CB'(rank_r[i]) == (used_r - CB'(1)));
    end
    inv     = ~valid_r;
    free_oh = inv & (~inv + N'(1));
    hit     = |match;
    room    = MB'(used_r) < cap_eff;
    put_new = is_put && !hit;
    upd     = hit || is_put;

    if (hit) begin
      sel = match;
    end else if (room) begin
      sel = free_oh;
    end else begin
      sel = oldest_oh;
    end

    sel_rank = '0;
    sel_key  = '0;
    sel_val  = '0;
    for (int i = 0; i < N; i++) begin
      if (sel[i]) begin
        sel_rank = sel_rank | rank_r[i];
        sel_key  = sel_key | key_r[i];
        sel_val  = sel_val | val_r[i];
      end
    end

    // A new slot ages every valid entry; a touched entry ages only the younger ones.
    thr = (put_new && room) ? used_r : CB'(sel_rank);
    for (int i = 0; i < N; i++) begin
      if (sel[i]) begin
        rank_nxt[i] = '0;
      end else if (valid_r[i] && (CB'(rank_r[i]) < thr)) begin
        rank_nxt[i] = rank_r[i] + RB'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
    valid_nxt = is_put ? (valid_r | sel) : valid_r;
    used_nxt  = (put_new && room) ? (used_r + CB'(1)) : used_r;

    out_data_nxt.hit         = hit;
    out_data_nxt.read_value  = (!is_put && hit) ? sel_val : '0;
    out_data_nxt.evicted     = put_new && !room;
    out_data_nxt.evicted_key = (put_new && !room) ? sel_key : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
      valid_r     <= '0;
      used_r      <= '0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (go && upd) begin
        valid_r <= valid_nxt;
        used_r  <= used_nxt;
        for (int i = 0; i < N; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (go) begin
      out_data_r <= out_data_nxt;
    end
    if (go && is_put) begin
      for (int i = 0; i < N; i++) begin
        if (sel[i]) begin
          key_r[i] <= s1_data_r.key;
          val_r[i] <= s1_data_r.value;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lkv_checker.sv =====
// Port-level checker for the LRU key/value cache, bound to lru_key_value_cache_top.
// Depends on lkv_pkg.
`default_nettype none

module lkv_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire lkv_pkg::lkv_out_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.evicted))
    else $error("Result shows both a hit and an eviction.");

  a_miss_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.read_value == '0)
    else $error("Read value is nonzero on a miss.");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted |-> out_data.evicted_key == '0)
    else $error("Evicted key is nonzero without an eviction.");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/lru_key_value_cache_top_tb.sv =====
// Self-checking testbench for lru_key_value_cache_top: directed and random puts and gets,
// checked against an LRU table predictor held in a small scoreboard class.
// Depends on lkv_pkg and lru_key_value_cache_top.
`timescale 1ns / 100ps

module lru_key_value_cache_top_tb;

  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 70;
  localparam logic [lkv_pkg::CAP_BITS-1:0] PHASE_CAPS [PHASE_COUNT] =
    '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd6, 4'd8, 4'd3, 4'd12, 4'd4, 4'd7, 4'd5};

  class lru_table_scoreboard;
    logic [lkv_pkg::KEY_BITS-1:0]   slot_key   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VALUE_BITS-1:0] slot_value [lkv_pkg::ENTRIES];
    bit                             slot_valid [lkv_pkg::ENTRIES];
    logic [lkv_pkg::RANK_BITS-1:0]  slot_rank  [lkv_pkg::ENTRIES];
    int unsigned                    fill_count;
    logic [lkv_pkg::CAP_BITS-1:0]   capacity;
    lkv_pkg::lkv_out_t              pending_results [$];
    int unsigned                    mismatches;

    function new();
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      fill_count = 0;
      capacity   = lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
      mismatches = 0;
    endfunction

    function int unsigned usable_slots();
      if (capacity == 0) return 1;
      if (capacity > lkv_pkg::ENTRIES) return lkv_pkg::ENTRIES;
      return capacity;
    endfunction

    function int lookup(logic [lkv_pkg::KEY_BITS-1:0] k);
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        if (!slot_valid[i]) return i;
      return -1;
    endfunction

    function int oldest();
      int best;
      best = -1;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        if (slot_valid[i] && (best < 0 || slot_rank[i] > slot_rank[best])) best = i;
      return best;
    endfunction

    function void promote(int s);
      logic [lkv_pkg::RANK_BITS-1:0] r;
      r = slot_rank[s];
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = '0;
    endfunction

    function void note_access(lkv_pkg::lkv_in_t a);
      lkv_pkg::lkv_out_t res;
      int s;
      res = '0;
      s = lookup(a.key);
      if (a.command == lkv_pkg::CMD_GET) begin
        if (s >= 0) begin
          res.hit        = 1'b1;
          res.read_value = slot_value[s];
          promote(s);
        end
      end else if (s >= 0) begin
        res.hit       = 1'b1;
        slot_value[s] = a.value;
        promote(s);
      end else begin
        if (fill_count < usable_slots()) s = first_free();
        if (s >= 0) begin
          for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (slot_valid[i]) slot_rank[i]++;
          slot_valid[s] = 1'b1;
          fill_count++;
        end else begin
          s = oldest();
          res.evicted     = 1'b1;
          res.evicted_key = slot_key[s];
        end
        slot_key[s]   = a.key;
        slot_value[s] = a.value;
        promote(s);
      end
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    task check_response(lkv_pkg::lkv_out_t got);
      lkv_pkg::lkv_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no access waiting", 64'd0, 64'(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", 64'(want.hit), 64'(got.hit));
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", 64'(want.read_value), 64'(got.read_value));
      if (got.evicted !== want.evicted)
        report_mismatch("evicted", 64'(want.evicted), 64'(got.evicted));
      if (got.evicted_key !== want.evicted_key)
        report_mismatch("evicted_key", 64'(want.evicted_key), 64'(got.evicted_key));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  lkv_pkg::lkv_in_t             in_data;
  logic                         out_valid;
  logic                         out_ready;
  lkv_pkg::lkv_out_t            out_data;
  logic                         cfg_wr_en;
  logic [lkv_pkg::CAP_BITS-1:0] cfg_wr_data;

  lru_table_scoreboard cache_model = new();
  bit                  steady_flow;
  bit                  hold_off_request;

  lru_key_value_cache_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("lru_key_value_cache_top verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic lkv_pkg::lkv_in_t access(lkv_pkg::cmd_t cmd,
                                              logic [lkv_pkg::KEY_BITS-1:0] k,
                                              logic [lkv_pkg::VALUE_BITS-1:0] v);
    lkv_pkg::lkv_in_t a;
    a.command = cmd;
    a.key     = k;
    a.value   = v;
    return a;
  endfunction

  task automatic send_access(lkv_pkg::lkv_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    cache_model.note_access(item);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CAP_BITS-1:0] cap);
    in_valid <= 1'b0;
    while (cache_model.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cache_model.capacity = cap;
  endtask

  task automatic run_directed_accesses();
    send_access(access(lkv_pkg::CMD_GET, 16'h0000, 32'h1234_5678));
    send_access(access(lkv_pkg::CMD_PUT, 16'h0000, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF));
    send_access(access(lkv_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_GET, 16'h0000, 32'hFFFF_FFFF));
    send_access(access(lkv_pkg::CMD_PUT, 16'h0000, 32'hA5A5_A5A5));
    for (int k = 1; k <= 6; k++)
      send_access(access(lkv_pkg::CMD_PUT, 16'(k), 32'h1000_0000 + k));
    send_access(access(lkv_pkg::CMD_PUT, 16'h0007, 32'h5555_5555));
    send_access(access(lkv_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_GET, 16'h0000, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_PUT, 16'hFFFF, 32'h5A5A_5A5A));
    send_access(access(lkv_pkg::CMD_GET, 16'h0001, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_GET, 16'h0002, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_PUT, 16'h8000, 32'h8000_0000));
    send_access(access(lkv_pkg::CMD_GET, 16'h0007, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_PUT, 16'h0007, 32'h0000_0001));
    send_access(access(lkv_pkg::CMD_GET, 16'h0007, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_GET, 16'h0007, 32'h0000_0000));
    send_access(access(lkv_pkg::CMD_GET, 16'h1234, 32'h0000_0000));
  endtask

  task automatic run_random_phase(int count);
    logic [lkv_pkg::KEY_BITS-1:0] key_pool [16];
    int                           pool_size;
    lkv_pkg::lkv_in_t             item;
    pool_size = $urandom_range(2, 14);
    for (int i = 0; i < 16; i++) key_pool[i] = lkv_pkg::KEY_BITS'($urandom);
    for (int n = 0; n < count; n++) begin
      item.command = ($urandom_range(0, 1) == 1) ? lkv_pkg::CMD_GET : lkv_pkg::CMD_PUT;
      if ($urandom_range(0, 9) == 0) item.key = lkv_pkg::KEY_BITS'($urandom);
      else item.key = key_pool[$urandom_range(0, pool_size - 1)];
      item.value = $urandom;
      send_access(item);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    steady_flow      = 1'b0;
    hold_off_request = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed_accesses();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_capacity(PHASE_CAPS[p]);
      steady_flow = (p == 3) || (p == 5) || (p == 8);
      if (p == 5) hold_off_request = 1'b1;
      run_random_phase(PHASE_ITEMS);
    end
    in_valid <= 1'b0;
    while (cache_model.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (cache_model.mismatches == 0) begin
      $display("lru_key_value_cache_top verification clean");
    end else begin
      $display("lru_key_value_cache_top verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall_left;
    int unsigned roll;
    stall_left = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) cache_model.check_response(out_data);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (steady_flow) begin
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(12, 40);
        end
      end
    end
  end

endmodule
